// File: hdl/est_pkg.sv
// -----------------------------------------------------------------------------
// est_pkg
// Shared types, constants and arithmetic helpers for the Euler/scale
// transform engine.
// -----------------------------------------------------------------------------
`default_nettype none

package est_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int TRIG_FRAC    = 30;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [31:0] I32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] I32_MIN = 32'sh8000_0000;

  // Mode codes
  localparam logic [1:0] MODE_YXZ = 2'd0;
  localparam logic [1:0] MODE_XYZ = 2'd1;

  // One CORDIC lane: rotating vector plus residual phase
  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [31:0] z;
  } est_rot_t;

  // Data that rides along the cell chain untouched
  typedef struct packed {
    logic [1:0]        mode;
    logic [2:0][1:0]   quad;
    logic [2:0][31:0]  scale;
    logic [2:0][31:0]  offset;
    logic [2:0][31:0]  mag;
  } est_side_t;

  // Per-step atan(2^-i), 2^-32 turn units
  function automatic logic signed [31:0] est_atan(input int i);
    logic signed [31:0] v;
    case (i)
      0:  v = 32'sd536870912;
      1:  v = 32'sd316933406;
      2:  v = 32'sd167458907;
      3:  v = 32'sd85004756;
      4:  v = 32'sd42667331;
      5:  v = 32'sd21354465;
      6:  v = 32'sd10679838;
      7:  v = 32'sd5340245;
      8:  v = 32'sd2670163;
      9:  v = 32'sd1335087;
      10: v = 32'sd667544;
      11: v = 32'sd333772;
      12: v = 32'sd166886;
      13: v = 32'sd83443;
      14: v = 32'sd41722;
      15: v = 32'sd20861;
      16: v = 32'sd10430;
      17: v = 32'sd5215;
      18: v = 32'sd2608;
      19: v = 32'sd1304;
      20: v = 32'sd652;
      21: v = 32'sd326;
      22: v = 32'sd163;
      23: v = 32'sd81;
      24: v = 32'sd41;
      25: v = 32'sd20;
      26: v = 32'sd10;
      27: v = 32'sd5;
      28: v = 32'sd3;
      29: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  // Q30 x Q30 product, rounded half up back to Q30
  function automatic logic signed [32:0] est_qmul(input logic signed [32:0] a,
                                                  input logic signed [32:0] b);
    logic signed [65:0] p;
    p = 66'(a) * 66'(b) + (66'sd1 <<< (TRIG_FRAC - 1));
    return p[62:30];
  endfunction

  // Saturate a 36-bit signed value to 32 bits
  function automatic logic signed [31:0] est_sat(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'(I32_MAX)) r = I32_MAX;
    else if (v < 36'(I32_MIN)) r = I32_MIN;
    else r = v[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/est_cell.sv
// -----------------------------------------------------------------------------
// est_cell
// One link of the chain: a CORDIC micro-rotation for all three angles and
// one restoring-division bit for all three reciprocal scales, else pass-through.
// -----------------------------------------------------------------------------
`default_nettype none

module est_cell #(
  parameter int IDX   = 0,
  parameter int NUM_W = 33
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  valid_i,
  input  wire est_pkg::est_side_t    side_i,
  input  wire est_pkg::est_rot_t     rot_i [3],
  input  wire logic [NUM_W-1:0]      num_i [3],
  input  wire logic [31:0]           rem_i [3],
  input  wire logic [NUM_W-1:0]      quo_i [3],
  output logic                       valid_o,
  output est_pkg::est_side_t         side_o,
  output est_pkg::est_rot_t          rot_o [3],
  output logic [NUM_W-1:0]           num_o [3],
  output logic [31:0]                rem_o [3],
  output logic [NUM_W-1:0]           quo_o [3]
);
  import est_pkg::*;

  est_rot_t         rot_d [3];
  logic [NUM_W-1:0] num_d [3];
  logic [31:0]      rem_d [3];
  logic [NUM_W-1:0] quo_d [3];

  // Per-lane step logic
  always_comb begin
    logic [32:0] trial;
    logic [32:0] dvs;
    for (int l = 0; l < 3; l++) begin
      rot_d[l] = rot_i[l];
      num_d[l] = num_i[l];
      rem_d[l] = rem_i[l];
      quo_d[l] = quo_i[l];
      trial    = '0;
      dvs      = '0;
      if (IDX < CORDIC_STEPS) begin
        if (!rot_i[l].z[31]) begin
          rot_d[l].x = rot_i[l].x - (rot_i[l].y >>> IDX);
          rot_d[l].y = rot_i[l].y + (rot_i[l].x >>> IDX);
          rot_d[l].z = rot_i[l].z - est_atan(IDX);
        end else begin
          rot_d[l].x = rot_i[l].x + (rot_i[l].y >>> IDX);
          rot_d[l].y = rot_i[l].y - (rot_i[l].x >>> IDX);
          rot_d[l].z = rot_i[l].z + est_atan(IDX);
        end
      end
      if (IDX < NUM_W) begin
        trial    = {rem_i[l], num_i[l][NUM_W-1]};
        dvs      = {1'b0, side_i.mag[l]};
        num_d[l] = num_i[l] << 1;
        if (trial >= dvs) begin
          rem_d[l] = 32'(trial - dvs);
          quo_d[l] = {quo_i[l][NUM_W-2:0], 1'b1};
        end else begin
          rem_d[l] = trial[31:0];
          quo_d[l] = {quo_i[l][NUM_W-2:0], 1'b0};
        end
      end
    end
  end

  // Valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      for (int l = 0; l < 3; l++) begin
        rot_o[l] <= rot_d[l];
        num_o[l] <= num_d[l];
        rem_o[l] <= rem_d[l];
        quo_o[l] <= quo_d[l];
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/est_matrix.sv
// -----------------------------------------------------------------------------
// est_matrix
// Back end: quadrant fold, reciprocal finish, rotation products, column
// scaling, rounding and saturation. Six register stages.
// -----------------------------------------------------------------------------
`default_nettype none

module est_matrix #(
  parameter int NUM_W = 33
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire est_pkg::est_side_t side_i,
  input  wire est_pkg::est_rot_t  rot_i [3],
  input  wire logic [NUM_W-1:0]   quo_i [3],
  output logic                    valid_o,
  output logic signed [31:0]      ent_o [9],
  output logic signed [31:0]      move_o [3]
);
  import est_pkg::*;

  // Product slots
  localparam int P_CYCZ = 0;
  localparam int P_SYSX = 1;
  localparam int P_CXSZ = 2;
  localparam int P_CYSX = 3;
  localparam int P_CZSY = 4;
  localparam int P_CXCZ = 5;
  localparam int P_CXSY = 6;
  localparam int P_CXCY = 7;
  localparam int P_CYSZ = 8;
  localparam int P_CZSX = 9;
  localparam int P_SXSZ = 10;
  localparam int P_SYSZ = 11;
  localparam int NPROD  = 12;

  localparam logic [NUM_W-1:0] QMAX = NUM_W'(32'h7fff_ffff);
  localparam logic [NUM_W-1:0] QNEG = NUM_W'(33'h0_8000_0000);

  logic [5:0] vld_q;

  // Stage 1: cos/sin after quadrant fold, column factors
  logic signed [32:0] c1_q [3], s1_q [3];
  logic signed [31:0] k1_q [3];
  logic [1:0]         mode1_q;
  logic [2:0][31:0]   off1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode1_q <= side_i.mode;
      off1_q  <= side_i.offset;
      for (int a = 0; a < 3; a++) begin
        case (side_i.quad[a])
          2'd0: begin c1_q[a] <= rot_i[a].x;  s1_q[a] <= rot_i[a].y;  end
          2'd1: begin c1_q[a] <= -rot_i[a].y; s1_q[a] <= rot_i[a].x;  end
          2'd2: begin c1_q[a] <= -rot_i[a].x; s1_q[a] <= -rot_i[a].y; end
          default: begin c1_q[a] <= rot_i[a].y; s1_q[a] <= -rot_i[a].x; end
        endcase
        if (!side_i.mode[1]) begin
          k1_q[a] <= side_i.scale[a];
        end else if (side_i.scale[a] == 32'd0) begin
          k1_q[a] <= I32_MAX;
        end else if (!side_i.scale[a][31]) begin
          k1_q[a] <= (quo_i[a] > QMAX) ? I32_MAX : quo_i[a][31:0];
        end else begin
          k1_q[a] <= (quo_i[a] > QNEG) ? I32_MIN : 32'(-quo_i[a]);
        end
      end
    end
  end

  // Stage 2: pairwise products
  logic signed [32:0] p2_q [NPROD];
  logic signed [32:0] sx2_q, sy2_q, sz2_q;
  logic signed [31:0] k2_q [3];
  logic [1:0]         mode2_q;
  logic [2:0][31:0]   off2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p2_q[P_CYCZ] <= est_qmul(c1_q[1], c1_q[2]);
      p2_q[P_SYSX] <= est_qmul(s1_q[1], s1_q[0]);
      p2_q[P_CXSZ] <= est_qmul(c1_q[0], s1_q[2]);
      p2_q[P_CYSX] <= est_qmul(c1_q[1], s1_q[0]);
      p2_q[P_CZSY] <= est_qmul(c1_q[2], s1_q[1]);
      p2_q[P_CXCZ] <= est_qmul(c1_q[0], c1_q[2]);
      p2_q[P_CXSY] <= est_qmul(c1_q[0], s1_q[1]);
      p2_q[P_CXCY] <= est_qmul(c1_q[0], c1_q[1]);
      p2_q[P_CYSZ] <= est_qmul(c1_q[1], s1_q[2]);
      p2_q[P_CZSX] <= est_qmul(c1_q[2], s1_q[0]);
      p2_q[P_SXSZ] <= est_qmul(s1_q[0], s1_q[2]);
      p2_q[P_SYSZ] <= est_qmul(s1_q[1], s1_q[2]);
      sx2_q   <= s1_q[0];
      sy2_q   <= s1_q[1];
      sz2_q   <= s1_q[2];
      k2_q    <= k1_q;
      mode2_q <= mode1_q;
      off2_q  <= off1_q;
    end
  end

  // Stage 3: triple products, operands picked by rotation order
  logic               xyz2;
  logic signed [32:0] m3_q [4];
  logic signed [32:0] p3_q [NPROD];
  logic signed [32:0] sx3_q, sy3_q;
  logic signed [31:0] k3_q [3];
  logic [1:0]         mode3_q;
  logic [2:0][31:0]   off3_q;

  assign xyz2 = (mode2_q == MODE_XYZ);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m3_q[0] <= xyz2 ? est_qmul(p2_q[P_CZSX], sy2_q) : est_qmul(p2_q[P_SYSX], sz2_q);
      m3_q[1] <= xyz2 ? est_qmul(p2_q[P_SYSX], sz2_q) : est_qmul(p2_q[P_CYSX], sz2_q);
      m3_q[2] <= xyz2 ? est_qmul(p2_q[P_CXCZ], sy2_q) : est_qmul(p2_q[P_CZSY], sx2_q);
      m3_q[3] <= xyz2 ? est_qmul(p2_q[P_CXSY], sz2_q) : est_qmul(p2_q[P_CYCZ], sx2_q);
      p3_q    <= p2_q;
      sx3_q   <= sx2_q;
      sy3_q   <= sy2_q;
      k3_q    <= k2_q;
      mode3_q <= mode2_q;
      off3_q  <= off2_q;
    end
  end

  // Stage 4: rotation entries
  logic               xyz3;
  logic signed [32:0] r4_q [9];
  logic signed [31:0] k4_q [3];
  logic               nrm4_q;
  logic [2:0][31:0]   off4_q;

  assign xyz3 = (mode3_q == MODE_XYZ);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (xyz3) begin
        r4_q[0] <= p3_q[P_CYCZ];
        r4_q[1] <= p3_q[P_CYSZ];
        r4_q[2] <= -sy3_q;
        r4_q[3] <= p3_q[P_CXSZ] + m3_q[0];
        r4_q[4] <= p3_q[P_CXCZ] - m3_q[1];
        r4_q[5] <= p3_q[P_CYSX];
        r4_q[6] <= p3_q[P_SXSZ] - m3_q[2];
        r4_q[7] <= p3_q[P_CZSX] + m3_q[3];
        r4_q[8] <= p3_q[P_CXCY];
      end else begin
        r4_q[0] <= p3_q[P_CYCZ] + m3_q[0];
        r4_q[1] <= p3_q[P_CXSZ];
        r4_q[2] <= m3_q[1] - p3_q[P_CZSY];
        r4_q[3] <= m3_q[2] - p3_q[P_CYSZ];
        r4_q[4] <= p3_q[P_CXCZ];
        r4_q[5] <= m3_q[3] + p3_q[P_SYSZ];
        r4_q[6] <= p3_q[P_CXSY];
        r4_q[7] <= -sx3_q;
        r4_q[8] <= p3_q[P_CXCY];
      end
      k4_q   <= k3_q;
      nrm4_q <= mode3_q[1];
      off4_q <= off3_q;
    end
  end

  // Stage 5: scale each column
  logic signed [64:0] x5_q [9];
  logic               nrm5_q;
  logic [2:0][31:0]   off5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 9; j++) begin
        x5_q[j] <= 65'(r4_q[j]) * 65'(k4_q[j/3]);
      end
      nrm5_q <= nrm4_q;
      off5_q <= off4_q;
    end
  end

  // Stage 6: round half up and saturate; offsets out, zeroed when mode[1] is set
  always_ff @(posedge clk_i) begin
    logic signed [65:0] t;
    if (en_i) begin
      for (int j = 0; j < 9; j++) begin
        t = 66'(x5_q[j]) + (66'sd1 <<< (TRIG_FRAC - 1));
        ent_o[j] <= est_sat(t[65:30]);
      end
      for (int a = 0; a < 3; a++) begin
        move_o[a] <= nrm5_q ? 32'sd0 : off5_q[a];
      end
    end
  end

  // Valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  assign valid_o = vld_q[5];

endmodule

`default_nettype wire

// File: hdl/euler_scale_transform_matrix.sv
// -----------------------------------------------------------------------------
// euler_scale_transform_matrix
// Rotation (Tait-Bryan angles) times scale plus translation, Q16.16 out.
// -----------------------------------------------------------------------------
//   channel  signals                         direction
//   in       in_valid_i / in_stall_o + fields  accepted when valid & !stall
//   out      out_valid_o / out_stall_i + fields taken when valid & !stall
//
// One transaction per cycle unless stalled; CHAIN cells feed the back end,
// CHAIN being the longer of the 30-step CORDIC and the NUM_W-bit reciprocal
// divider (33 cells at FRAC_BITS = 16). Reset empties the pipeline. A stalled
// result freezes the whole pipeline and stalls the input in the same cycle.
// -----------------------------------------------------------------------------
`default_nettype none

module euler_scale_transform_matrix #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [1:0]              mode_i,
  input  wire logic [ANGLE_BITS-1:0]   angle_x_i,
  input  wire logic [ANGLE_BITS-1:0]   angle_y_i,
  input  wire logic [ANGLE_BITS-1:0]   angle_z_i,
  input  wire logic signed [31:0]      scale_x_i,
  input  wire logic signed [31:0]      scale_y_i,
  input  wire logic signed [31:0]      scale_z_i,
  input  wire logic signed [31:0]      offset_x_i,
  input  wire logic signed [31:0]      offset_y_i,
  input  wire logic signed [31:0]      offset_z_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic signed [31:0]           col0_row0_o,
  output logic signed [31:0]           col0_row1_o,
  output logic signed [31:0]           col0_row2_o,
  output logic signed [31:0]           col1_row0_o,
  output logic signed [31:0]           col1_row1_o,
  output logic signed [31:0]           col1_row2_o,
  output logic signed [31:0]           col2_row0_o,
  output logic signed [31:0]           col2_row1_o,
  output logic signed [31:0]           col2_row2_o,
  output logic signed [31:0]           move_x_o,
  output logic signed [31:0]           move_y_o,
  output logic signed [31:0]           move_z_o
);
  import est_pkg::*;

  localparam int NUM_W = ((2 * FRAC_BITS > 31) ? 2 * FRAC_BITS : 31) + 1;
  localparam int CHAIN = (CORDIC_STEPS > NUM_W) ? CORDIC_STEPS : NUM_W;

  logic               en;
  logic               vld   [CHAIN+1];
  est_side_t          side  [CHAIN+1];
  est_rot_t           rot   [CHAIN+1][3];
  logic [NUM_W-1:0]   num   [CHAIN+1][3];
  logic [31:0]        rem   [CHAIN+1][3];
  logic [NUM_W-1:0]   quo   [CHAIN+1][3];
  logic [ANGLE_BITS-1:0] ang [3];
  logic [31:0]        scl   [3];
  logic signed [31:0] ent   [9];
  logic signed [31:0] mov   [3];

  // Whole pipeline moves unless a result is held
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  assign ang[0] = angle_x_i;
  assign ang[1] = angle_y_i;
  assign ang[2] = angle_z_i;
  assign scl[0] = scale_x_i;
  assign scl[1] = scale_y_i;
  assign scl[2] = scale_z_i;

  // Chain entry: phase split into quadrant and residual, divider seed
  always_comb begin
    logic [31:0] ph;
    logic [31:0] t;
    logic [31:0] m;
    vld[0]            = in_valid_i;
    side[0].mode      = mode_i;
    side[0].offset[0] = offset_x_i;
    side[0].offset[1] = offset_y_i;
    side[0].offset[2] = offset_z_i;
    for (int a = 0; a < 3; a++) begin
      ph = {ang[a], {(32 - ANGLE_BITS){1'b0}}};
      t  = ph + 32'h2000_0000;
      m  = scl[a][31] ? (32'd0 - scl[a]) : scl[a];
      side[0].quad[a]  = t[31:30];
      side[0].scale[a] = scl[a];
      side[0].mag[a]   = m;
      rot[0][a].x      = CORDIC_GAIN;
      rot[0][a].y      = '0;
      rot[0][a].z      = $signed({2'b00, t[29:0]}) - 32'sh2000_0000;
      num[0][a]        = (NUM_W'(1) << (2 * FRAC_BITS)) + NUM_W'(m >> 1);
      rem[0][a]        = '0;
      quo[0][a]        = '0;
    end
  end

  // Cell chain
  for (genvar g = 0; g < CHAIN; g++) begin : g_cell
    est_cell #(
      .IDX   (g),
      .NUM_W (NUM_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld[g]),
      .side_i  (side[g]),
      .rot_i   (rot[g]),
      .num_i   (num[g]),
      .rem_i   (rem[g]),
      .quo_i   (quo[g]),
      .valid_o (vld[g+1]),
      .side_o  (side[g+1]),
      .rot_o   (rot[g+1]),
      .num_o   (num[g+1]),
      .rem_o   (rem[g+1]),
      .quo_o   (quo[g+1])
    );
  end

  // Matrix back end
  est_matrix #(
    .NUM_W (NUM_W)
  ) u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld[CHAIN]),
    .side_i  (side[CHAIN]),
    .rot_i   (rot[CHAIN]),
    .quo_i   (quo[CHAIN]),
    .valid_o (out_valid_o),
    .ent_o   (ent),
    .move_o  (mov)
  );

  assign col0_row0_o = ent[0];
  assign col0_row1_o = ent[1];
  assign col0_row2_o = ent[2];
  assign col1_row0_o = ent[3];
  assign col1_row1_o = ent[4];
  assign col1_row2_o = ent[5];
  assign col2_row0_o = ent[6];
  assign col2_row1_o = ent[7];
  assign col2_row2_o = ent[8];
  assign move_x_o    = mov[0];
  assign move_y_o    = mov[1];
  assign move_z_o    = mov[2];

endmodule

`default_nettype wire

// File: hdl/est_checker.sv
// -----------------------------------------------------------------------------
// est_checker
// Port-level checks for the transform engine, bound to the top level.
// -----------------------------------------------------------------------------
`default_nettype none

module est_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic signed [31:0] col0_row0_o
);

  // Input stalls exactly when a result is held back
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall not tied to output back pressure");

  // Nothing comes out straight after reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result present after reset");

  // A held result stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A held result keeps its value (col0_row0_o is the entry checked)
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(col0_row0_o))
    else $error("result changed while stalled");

endmodule

bind euler_scale_transform_matrix est_checker u_est_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .col0_row0_o (col0_row0_o)
);

`default_nettype wire
